>>> hdl/fcm_pkg.sv
// ---------------------------------------------------------------------------
// fcm_pkg: shared types and constants of the false color map
// Gradient codes, fixed-point widths and parameter defaults.
// ---------------------------------------------------------------------------
package fcm_pkg;

   localparam int DEF_INDEX_WIDTH = 16;
   localparam int DEF_LEVEL_WIDTH = 8;
   localparam int COUNT_RESET     = 256;

   // position t: 16 fraction bits, 1.0 representable
   localparam int FRAC_BITS = 16;
   localparam int T_W       = FRAC_BITS + 1;
   // color values in 2^-17 units, 1.0 = 2^17
   localparam int C_W       = FRAC_BITS + 2;

   localparam int CMD_W = 3;
   typedef logic [CMD_W-1:0] cmd_type;
   localparam cmd_type CMD_GREY = 3'd0;
   localparam cmd_type CMD_JET  = 3'd1;
   localparam cmd_type CMD_HOT  = 3'd2;
   localparam cmd_type CMD_HSV  = 3'd3;
   localparam cmd_type CMD_SHSV = 3'd4;

   typedef logic [T_W-1:0] pos_type;
   typedef logic [C_W-1:0] color_type;

endpackage

>>> hdl/fcm_if.sv
// ---------------------------------------------------------------------------
// fcm_if: channel interfaces of the false color map
// Request, response and register write channels, valid/ready handshake.
// ---------------------------------------------------------------------------
interface fcm_req_if #(parameter int INDEX_WIDTH = 16);
   logic                   valid;
   logic                   ready;
   logic [2:0]             cmd;
   logic [INDEX_WIDTH-1:0] bucket_index;
   modport source (output valid, cmd, bucket_index, input ready);
   modport sink   (input valid, cmd, bucket_index, output ready);
endinterface

interface fcm_rsp_if #(parameter int LEVEL_WIDTH = 8);
   logic                   valid;
   logic                   ready;
   logic [LEVEL_WIDTH-1:0] red_level;
   logic [LEVEL_WIDTH-1:0] green_level;
   logic [LEVEL_WIDTH-1:0] blue_level;
   modport source (output valid, red_level, green_level, blue_level, input ready);
   modport sink   (input valid, red_level, green_level, blue_level, output ready);
endinterface

interface fcm_csr_if #(parameter int INDEX_WIDTH = 16);
   logic                   valid;
   logic                   ready;
   logic [INDEX_WIDTH-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> hdl/fcm_divider.sv
// ---------------------------------------------------------------------------
// fcm_divider: pipelined position divider
// t = min(index * 2^16 / count, 1.0), two quotient bits per stage.
// ---------------------------------------------------------------------------
module fcm_divider #(
   parameter int INDEX_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  fcm_pkg::cmd_type       in_cmd,
   input  logic [INDEX_WIDTH-1:0] in_index,
   input  logic [INDEX_WIDTH-1:0] count,
   output logic                   out_valid,
   output fcm_pkg::cmd_type       out_cmd,
   output fcm_pkg::pos_type       out_t
);
   import fcm_pkg::*;

   localparam int NSTG = FRAC_BITS / 2;

   logic                   v_ff   [0:NSTG];
   cmd_type                cmd_ff [0:NSTG];
   logic                   sat_ff [0:NSTG];
   logic [INDEX_WIDTH-1:0] rem_ff [0:NSTG];
   logic [FRAC_BITS-1:0]   q_ff   [0:NSTG];

   // stage 0: saturation check, load remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
      if (adv) begin
         cmd_ff[0] <= in_cmd;
         sat_ff[0] <= (count == '0) || (in_index >= count);
         rem_ff[0] <= in_index;
         q_ff[0]   <= '0;
      end
   end

   for (genvar k = 1; k <= NSTG; k++) begin : g_stage
      logic [INDEX_WIDTH:0]   r1, r2;
      logic [INDEX_WIDTH-1:0] m1, m2;
      logic                   b1, b2;
      always_comb begin
         r1 = {rem_ff[k-1], 1'b0};
         b1 = r1 >= {1'b0, count};
         m1 = b1 ? INDEX_WIDTH'(r1 - {1'b0, count}) : r1[INDEX_WIDTH-1:0];
         r2 = {m1, 1'b0};
         b2 = r2 >= {1'b0, count};
         m2 = b2 ? INDEX_WIDTH'(r2 - {1'b0, count}) : r2[INDEX_WIDTH-1:0];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_ff[k-1];
         end
         if (adv) begin
            cmd_ff[k] <= cmd_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
            rem_ff[k] <= m2;
            q_ff[k]   <= {q_ff[k-1][FRAC_BITS-3:0], b1, b2};
         end
      end
   end

   assign out_valid = v_ff[NSTG];
   assign out_cmd   = cmd_ff[NSTG];
   assign out_t     = sat_ff[NSTG] ? pos_type'(1 << FRAC_BITS) : {1'b0, q_ff[NSTG]};

endmodule

>>> hdl/fcm_gradient.sv
// ---------------------------------------------------------------------------
// fcm_gradient: gradient evaluation stage
// Maps position t to r, g, b in 2^-17 units for the selected gradient.
// ---------------------------------------------------------------------------
module fcm_gradient (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  fcm_pkg::cmd_type      in_cmd,
   input  fcm_pkg::pos_type      in_t,
   output logic                  out_valid,
   output fcm_pkg::color_type    out_r,
   output fcm_pkg::color_type    out_g,
   output fcm_pkg::color_type    out_b
);
   import fcm_pkg::*;

   localparam logic [19:0] ONE_U  = 20'd1 << FRAC_BITS;
   localparam color_type   ONE2   = color_type'(1 << (FRAC_BITS + 1));

   logic [19:0] u;
   logic [18:0] x3, h;
   logic [2:0]  sector;
   color_type   f, q;
   color_type   r_in, g_in, b_in;
   logic        v_ff;
   color_type   r_ff, g_ff, b_ff;

   always_comb begin
      u      = {in_t, 3'b000};
      x3     = 19'({in_t, 1'b0}) + 19'(in_t);
      h      = (in_t >= pos_type'(1 << FRAC_BITS)) ? '0 : 19'(x3 << 1);
      sector = h[18:16];
      f      = {1'b0, h[15:0], 1'b0};
      q      = ONE2 - f;
      r_in   = '0;
      g_in   = '0;
      b_in   = '0;
      case (in_cmd)
         CMD_GREY: begin
            r_in = {in_t, 1'b0};
            g_in = {in_t, 1'b0};
            b_in = {in_t, 1'b0};
         end
         CMD_JET: begin
            if (u <= ONE_U) begin
               b_in = color_type'(ONE_U + u);
            end else if (u < 3 * ONE_U) begin
               g_in = color_type'(u - ONE_U);
               b_in = ONE2;
            end else if (u < 5 * ONE_U) begin
               r_in = color_type'(u - 3 * ONE_U);
               g_in = ONE2;
               b_in = color_type'(ONE2 - color_type'(u - 3 * ONE_U));
            end else if (u < 7 * ONE_U) begin
               r_in = ONE2;
               g_in = color_type'(ONE2 - color_type'(u - 5 * ONE_U));
            end else begin
               r_in = color_type'(ONE2 - color_type'(u - 7 * ONE_U));
            end
         end
         CMD_HOT: begin
            if (x3 <= 19'(ONE_U)) begin
               r_in = color_type'({x3, 1'b0});
            end else if (x3 <= 19'(2 * ONE_U)) begin
               r_in = ONE2;
               g_in = color_type'({x3 - 19'(ONE_U), 1'b0});
            end else begin
               r_in = ONE2;
               g_in = ONE2;
               b_in = color_type'({x3 - 19'(2 * ONE_U), 1'b0});
            end
         end
         CMD_HSV, CMD_SHSV: begin
            case (sector)
               3'd0: begin r_in = ONE2; g_in = f; end
               3'd1: begin r_in = q; g_in = ONE2; end
               3'd2: begin g_in = ONE2; b_in = f; end
               3'd3: begin g_in = q; b_in = ONE2; end
               3'd4: begin r_in = f; b_in = ONE2; end
               default: begin r_in = ONE2; b_in = q; end
            endcase
         end
         default: begin
            r_in = ONE2;
            g_in = ONE2;
            b_in = ONE2;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= in_valid;
      end
      if (adv) begin
         r_ff <= r_in;
         g_ff <= g_in;
         b_ff <= b_in;
      end
   end

   assign out_valid = v_ff;
   assign out_r     = r_ff;
   assign out_g     = g_ff;
   assign out_b     = b_ff;

endmodule

>>> hdl/fcm_level.sv
// ---------------------------------------------------------------------------
// fcm_level: level conversion and output register
// level = (x * (2^LW - 1) + 2^16) >> 17, round half up.
// ---------------------------------------------------------------------------
module fcm_level #(
   parameter int LEVEL_WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  fcm_pkg::color_type     in_r,
   input  fcm_pkg::color_type     in_g,
   input  fcm_pkg::color_type     in_b,
   output logic                   out_valid,
   output logic [LEVEL_WIDTH-1:0] out_r,
   output logic [LEVEL_WIDTH-1:0] out_g,
   output logic [LEVEL_WIDTH-1:0] out_b
);
   import fcm_pkg::*;

   localparam int PW = C_W + LEVEL_WIDTH;
   localparam logic [PW-1:0] LMAX = PW'((1 << LEVEL_WIDTH) - 1);
   localparam logic [PW-1:0] HALF = PW'(1) << FRAC_BITS;

   logic [PW-1:0] pr, pg, pb;
   logic v_ff;
   logic [LEVEL_WIDTH-1:0] r_ff, g_ff, b_ff;

   assign pr = PW'(in_r) * LMAX + HALF;
   assign pg = PW'(in_g) * LMAX + HALF;
   assign pb = PW'(in_b) * LMAX + HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= in_valid;
      end
      if (adv) begin
         r_ff <= pr[FRAC_BITS+1 +: LEVEL_WIDTH];
         g_ff <= pg[FRAC_BITS+1 +: LEVEL_WIDTH];
         b_ff <= pb[FRAC_BITS+1 +: LEVEL_WIDTH];
      end
   end

   assign out_valid = v_ff;
   assign out_r     = r_ff;
   assign out_g     = g_ff;
   assign out_b     = b_ff;

endmodule

>>> hdl/false_color_map_unit.sv
// ---------------------------------------------------------------------------
// false_color_map_unit: bucket index to RGB false color
// Pipelined grey/jet/hot/hsv gradient lookup; one pixel per clock if no stall.
// ---------------------------------------------------------------------------
// Usage:
//  - req channel: one beat = gradient code (cmd) + bucket_index.
//  - rsp channel: one beat = red/green/blue levels, all ones = full.
//  - csr channel: one beat writes bucket_count; write only while idle.
//  - A request beat, once taken, lands in the input stage, then passes
//    eight divider stages (two quotient bits each), one gradient stage
//    and the level multiply stage, which is the output register.
//  - Throughput one beat per clock unless rsp stalls; the divider
//    pipeline sets the depth.
//  - The whole pipeline moves as one: it advances when the output
//    register is empty or being taken. When rsp stalls, req_ready drops
//    in the same cycle and every stage holds; nothing is lost or repeated.
//  - Reset (synchronous) clears all valid bits and sets bucket_count to 256.
//  - Zero count or index past count saturates the position at 1.0.
//  - Unknown gradient codes give white.
// ---------------------------------------------------------------------------
module false_color_map_unit #(
   parameter int INDEX_WIDTH = fcm_pkg::DEF_INDEX_WIDTH,
   parameter int LEVEL_WIDTH = fcm_pkg::DEF_LEVEL_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   fcm_req_if.sink   req_bus,
   fcm_rsp_if.source rsp_bus,
   fcm_csr_if.sink   csr_bus
);
   import fcm_pkg::*;

   logic [INDEX_WIDTH-1:0] count_ff;
   logic                   adv;

   // divider -> gradient
   logic    div_valid;
   cmd_type div_cmd;
   pos_type div_t;

   // gradient -> level
   logic      grd_valid;
   color_type grd_r, grd_g, grd_b;

   // global pipeline enable: output register empty or drained this cycle
   assign adv           = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign csr_bus.ready = 1'b1;

   // bucket count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= INDEX_WIDTH'(COUNT_RESET);
      end else if (csr_bus.valid) begin
         count_ff <= csr_bus.data;
      end
   end

   fcm_divider #(.INDEX_WIDTH(INDEX_WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_bus.valid),
      .in_cmd    (req_bus.cmd),
      .in_index  (req_bus.bucket_index),
      .count     (count_ff),
      .out_valid (div_valid),
      .out_cmd   (div_cmd),
      .out_t     (div_t)
   );

   fcm_gradient u_grd (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_valid),
      .in_cmd    (div_cmd),
      .in_t      (div_t),
      .out_valid (grd_valid),
      .out_r     (grd_r),
      .out_g     (grd_g),
      .out_b     (grd_b)
   );

   fcm_level #(.LEVEL_WIDTH(LEVEL_WIDTH)) u_lvl (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (grd_valid),
      .in_r      (grd_r),
      .in_g      (grd_g),
      .in_b      (grd_b),
      .out_valid (rsp_bus.valid),
      .out_r     (rsp_bus.red_level),
      .out_g     (rsp_bus.green_level),
      .out_b     (rsp_bus.blue_level)
   );

`ifndef SYNTHESIS
   // position never exceeds 1.0
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      div_valid |-> (div_t <= pos_type'(1 << FRAC_BITS)))
      else $error("position above 1.0");

   // a stalled output freezes the gradient stage
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> ($stable(grd_r) && $stable(grd_valid)))
      else $error("pipeline moved during stall");

   // color values stay within 1.0
   a_color_range: assert property (@(posedge clock) disable iff (reset)
      grd_valid |-> (grd_r <= color_type'(1 << (FRAC_BITS + 1)) &&
                     grd_g <= color_type'(1 << (FRAC_BITS + 1)) &&
                     grd_b <= color_type'(1 << (FRAC_BITS + 1))))
      else $error("color value above 1.0");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the false color map
// Drives gradient/bucket beats with random gaps, predicts each color from
// the bucket count in force and compares every response beat in order.
// ---------------------------------------------------------------------------
module tb_top;
   import fcm_pkg::*;

   localparam int IW = 16;
   localparam int LW = 8;
   localparam int LATENCY = 10;
   localparam longint LIMIT = 400000;

   // one pending request beat
   typedef struct packed {
      cmd_type       cmd;
      logic [IW-1:0] bucket;
   } pixel_type;

   // one expected color
   typedef struct packed {
      logic [LW-1:0] red;
      logic [LW-1:0] green;
      logic [LW-1:0] blue;
   } rgb_type;

   logic clock;
   logic reset;

   fcm_req_if #(.INDEX_WIDTH(IW)) req_bus ();
   fcm_rsp_if #(.LEVEL_WIDTH(LW)) rsp_bus ();
   fcm_csr_if #(.INDEX_WIDTH(IW)) csr_bus ();

   false_color_map_unit #(.INDEX_WIDTH(IW), .LEVEL_WIDTH(LW)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   pixel_type pixel_queue[$];  // beats waiting for the driver
   rgb_type   color_queue[$];  // colors waiting for their response beat
   logic [IW-1:0] count_model; // predictor's copy of bucket_count
   int      fail_count;
   longint  cycle_count;
   bit      hold_rsp;          // long receiver stall request
   bit      traffic_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // gap length: mostly 0..2, sometimes long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 90) return $urandom_range(1, 2);
      return $urandom_range(5, 30);
   endfunction

   // value in 2^-17 units -> level, round half up
   function automatic logic [LW-1:0] level_of(longint unsigned x);
      longint unsigned lv;
      lv = (x * ((1 << LW) - 1) + (1 << FRAC_BITS)) >> (FRAC_BITS + 1);
      if (lv > (1 << LW) - 1) lv = (1 << LW) - 1;
      return lv[LW-1:0];
   endfunction

   // predicted color of one pixel under the current bucket count
   function automatic rgb_type shade_pixel(pixel_type px);
      longint unsigned one, one2, t, u, x, h, f, q, r, g, b;
      int sector;
      rgb_type c;
      one  = 64'd1 << FRAC_BITS;
      one2 = 2 * one;
      r = 0; g = 0; b = 0;
      if (count_model == 0) t = one;
      else begin
         t = (longint'(px.bucket) << FRAC_BITS) / count_model;
         if (t > one) t = one;
      end
      case (px.cmd)
         CMD_GREY: begin
            r = 2 * t; g = r; b = r;
         end
         CMD_JET: begin
            u = 8 * t;
            if (u <= one) b = one + u;
            else if (u < 3 * one) begin
               g = u - one; b = one2;
            end else if (u < 5 * one) begin
               r = u - 3 * one; g = one2; b = one2 - r;
            end else if (u < 7 * one) begin
               r = one2; g = one2 - (u - 5 * one);
            end else r = one2 - (u - 7 * one);
         end
         CMD_HOT: begin
            x = 3 * t;
            if (x <= one) r = 2 * x;
            else if (x <= 2 * one) begin
               r = one2; g = 2 * (x - one);
            end else begin
               r = one2; g = one2; b = 2 * (x - 2 * one);
            end
         end
         CMD_HSV, CMD_SHSV: begin
            h = (t >= one) ? 0 : 6 * t;   // hue of 360 wraps to 0
            sector = int'(h >> FRAC_BITS);
            f = 2 * (h & (one - 1));
            q = one2 - f;
            case (sector)
               0: begin r = one2; g = f; end
               1: begin r = q; g = one2; end
               2: begin g = one2; b = f; end
               3: begin g = q; b = one2; end
               4: begin r = f; b = one2; end
               default: begin r = one2; b = q; end
            endcase
         end
         default: begin
            r = one2; g = one2; b = one2;   // unsupported code -> white
         end
      endcase
      c.red   = level_of(r);
      c.green = level_of(g);
      c.blue  = level_of(b);
      return c;
   endfunction

   // ---------------- driver: request channel ----------------
   int req_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid        <= 1'b0;
         req_bus.cmd          <= '0;
         req_bus.bucket_index <= '0;
         req_gap              <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            color_queue.push_back(shade_pixel({req_bus.cmd, req_bus.bucket_index}));
         end
         if (!req_bus.valid || req_bus.ready) begin
            // slot is free: offer the next beat or idle
            if (req_gap > 0) begin
               req_gap       <= req_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (traffic_on && pixel_queue.size() > 0) begin
               pixel_type px;
               px = pixel_queue.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.cmd          <= px.cmd;
               req_bus.bucket_index <= px.bucket;
               req_gap              <= pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor: response channel ----------------
   int rsp_gap;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap       <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (color_queue.size() == 0) begin
               $error("response beat with nothing expected");
               fail_count = fail_count + 1;
            end else begin
               rgb_type exp;
               exp = color_queue.pop_front();
               if (rsp_bus.red_level !== exp.red) begin
                  $error("red_level expected %0d actual %0d", exp.red, rsp_bus.red_level);
                  fail_count = fail_count + 1;
               end
               if (rsp_bus.green_level !== exp.green) begin
                  $error("green_level expected %0d actual %0d",
                         exp.green, rsp_bus.green_level);
                  fail_count = fail_count + 1;
               end
               if (rsp_bus.blue_level !== exp.blue) begin
                  $error("blue_level expected %0d actual %0d",
                         exp.blue, rsp_bus.blue_level);
                  fail_count = fail_count + 1;
               end
            end
         end
         // stall pattern: random gaps, plus a forced long hold
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap       <= rsp_gap - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            rsp_gap       <= pick_gap();
         end
      end
   end

   // long receiver hold, counted in its own process, started while a
   // large batch is still waiting so the pipeline fills and req stalls
   initial begin
      hold_rsp = 1'b0;
      do @(negedge clock); while (!(traffic_on && pixel_queue.size() > 100));
      hold_rsp = 1'b1;
      repeat (200) @(negedge clock);
      hold_rsp = 1'b0;
   end

   // timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // register write, only while the pipeline is empty
   task automatic write_count(input logic [IW-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      count_model = value;
      csr_bus.valid <= 1'b0;
   endtask

   // let every queued beat be sent and answered
   task automatic drain();
      traffic_on = 1'b1;
      do @(negedge clock);
      while (pixel_queue.size() != 0 || req_bus.valid || color_queue.size() != 0);
      traffic_on = 1'b0;
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic add_pixel(input cmd_type cmd, input logic [IW-1:0] bucket);
      pixel_queue.push_back({cmd, bucket});
   endtask

   // random phase: buckets mostly within the count, some past it
   task automatic random_phase(input int n);
      logic [IW-1:0] bkt;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 8 && count_model != 0)
            bkt = IW'($urandom_range(0, count_model));
         else
            bkt = IW'($urandom);
         add_pixel(cmd_type'($urandom_range(0, 7)), bkt);
      end
   endtask

   initial begin
      logic [IW-1:0] settings [6];
      reset         = 1'b1;
      traffic_on    = 1'b0;
      fail_count    = 0;
      cycle_count   = 0;
      count_model   = COUNT_RESET;
      csr_bus.valid = 1'b0;
      csr_bus.data  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: every gradient code at its start and midpoint, then odd cases
      for (int c = 0; c < 8; c++) begin
         add_pixel(cmd_type'(c), 16'd0);
         add_pixel(cmd_type'(c), 16'd128);
      end
      add_pixel(CMD_JET, 16'd224);      // start of repaired last jet segment
      add_pixel(CMD_JET, 16'd256);      // red ends at one half
      add_pixel(CMD_HSV, 16'd256);      // hue wraps to 0
      add_pixel(CMD_HOT, 16'hFFFF);     // index far past count
      add_pixel(CMD_GREY, 16'd255);
      drain();

      // count zero saturates position
      write_count(16'd0);
      add_pixel(CMD_GREY, 16'd0);
      add_pixel(CMD_JET, 16'hFFFF);
      drain();

      settings = '{16'd1, 16'hFFFF, 16'd3, 16'd1000, 16'd37, 16'd256};
      foreach (settings[k]) begin
         write_count(settings[k]);
         random_phase(180);
         drain();
      end

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> false_color_map_unit.f
hdl/fcm_pkg.sv
hdl/fcm_if.sv
hdl/fcm_divider.sv
hdl/fcm_gradient.sv
hdl/fcm_level.sv
hdl/false_color_map_unit.sv
tb/tb_top.sv
